// File: design/swlr_pkg.sv
// Shared types, codes and helpers for the stopwatch with lap ring.
// No dependencies; every other design file imports this package.
package swlr_pkg;

	localparam int TIME_W   = 23;
	localparam int STEP_W   = 10;
	localparam int LIDX_W   = 6;
	localparam int HELD_W   = 7;
	localparam int LAPNUM_W = 16;

	localparam logic [TIME_W-1:0] TIME_MAX = 23'd5999999;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_LEFT  = 2'd1,
		CMD_RIGHT = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// reported state codes
	localparam logic [1:0] RS_IDLE  = 2'd0;
	localparam logic [1:0] RS_RUN   = 2'd1;
	localparam logic [1:0] RS_PAUSE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_PAUSE = 3'b100
	} run_st_t;

	// decoded command, one flag per kind
	typedef struct packed {
		logic              tick;
		logic              left;
		logic              right;
		logic              rd;
		logic [LIDX_W-1:0] lap_index;
	} op_t;

	typedef struct packed {
		logic [1:0]          run_state;
		logic [HELD_W-1:0]   laps_held;
		logic [LAPNUM_W-1:0] lap_number;
		logic                lap_valid;
	} info_t;

	typedef struct packed {
		info_t             info;
		logic              lap_sel;
		logic [TIME_W-1:0] elapsed;
	} exec_res_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	function automatic logic [1:0] run_code(input run_st_t s);
		logic [1:0] c;
		case (s)
			ST_RUN:   c = RS_RUN;
			ST_PAUSE: c = RS_PAUSE;
			default:  c = RS_IDLE;
		endcase
		return c;
	endfunction

	// two decimal digits of a value below 100; v*205 >> 11 is exact there
	function automatic digits_t split10(input logic [6:0] v);
		logic [14:0] p;
		digits_t     d;
		p = 15'(v) * 15'd205;
		d.tens = p[14:11];
		d.ones = 4'(v - 7'(d.tens) * 7'd10);
		return d;
	endfunction

endpackage

// File: design/stopwatch_with_lap_ring.sv
// Top level of the stopwatch with lap ring: tick step register, command
// queue, execute stage with lap memory, and digit formatting pipeline.
// Depends on swlr_pkg, swlr_front, swlr_exec, swlr_fmt.
//
//   channel   handshake             payload
//   cfg       cfg_valid/cfg_ready   cfg_data (tick step, ms)
//   in        in_valid/in_stall     cmd, lap_index
//   out       out_valid/out_stall   run_state, time_ms, digits, laps_held,
//                                   lap_number, lap_valid
//
// One transaction per cycle sustained while out_stall is low. The queue
// slot is written at the accepting edge, then the execute register (lap
// memory read) and six formatting registers follow before out_valid rises.
// Reset clears control state only; the lap memory is not cleared.
// out_stall freezes the whole back end while out_valid is high; the
// two-entry queue keeps taking input until full, then in_stall rises.
module stopwatch_with_lap_ring #(
	parameter int LAP_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [5:0]  lap_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  run_state,
	output logic [22:0] time_ms,
	output logic [3:0]  min_tens,
	output logic [3:0]  min_ones,
	output logic [2:0]  sec_tens,
	output logic [3:0]  sec_ones,
	output logic [3:0]  centi_tens,
	output logic [3:0]  centi_ones,
	output logic [6:0]  laps_held,
	output logic [15:0] lap_number,
	output logic        lap_valid
);
	import swlr_pkg::*;

	logic [STEP_W-1:0] tick_step_q;
	logic              adv;
	logic              pop;
	logic              q_vld;
	op_t               q_op;
	logic              vld_s1;
	exec_res_t         res_s1;
	logic [TIME_W-1:0] lap_time_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= STEP_W'(50);
		end else if (cfg_valid && cfg_ready) begin
			tick_step_q <= cfg_data;
		end
	end

	swlr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.lap_index (lap_index),
		.pop       (pop),
		.q_vld     (q_vld),
		.q_op      (q_op)
	);

	swlr_exec #(
		.LAP_DEPTH (LAP_DEPTH)
	) u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.tick_step   (tick_step_q),
		.q_vld       (q_vld),
		.q_op        (q_op),
		.pop         (pop),
		.vld_s1      (vld_s1),
		.res_s1      (res_s1),
		.lap_time_s1 (lap_time_s1)
	);

	swlr_fmt u_fmt (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.vld_s1      (vld_s1),
		.res_s1      (res_s1),
		.lap_time_s1 (lap_time_s1),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.run_state   (run_state),
		.time_ms     (time_ms),
		.min_tens    (min_tens),
		.min_ones    (min_ones),
		.sec_tens    (sec_tens),
		.sec_ones    (sec_ones),
		.centi_tens  (centi_tens),
		.centi_ones  (centi_ones),
		.laps_held   (laps_held),
		.lap_number  (lap_number),
		.lap_valid   (lap_valid)
	);

endmodule

// File: design/swlr_front.sv
// Front end: two-entry command queue that decodes each transaction on entry.
// Depends on swlr_pkg.
module swlr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [swlr_pkg::LIDX_W-1:0]    lap_index,
	input  logic                           pop,
	output logic                           q_vld,
	output swlr_pkg::op_t                  q_op
);
	import swlr_pkg::*;

	op_t        slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;
	op_t        dec;

	always_comb begin
		dec = '0;
		dec.lap_index = lap_index;
		case (cmd_t'(cmd))
			CMD_TICK:  dec.tick  = 1'b1;
			CMD_LEFT:  dec.left  = 1'b1;
			CMD_RIGHT: dec.right = 1'b1;
			default:   dec.rd    = 1'b1;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_vld    = (cnt_q != 2'd0);
	assign do_pop   = pop && q_vld;
	assign q_op     = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (do_pop)
				rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

// File: design/swlr_exec.sv
// Back end, first stage: run state, elapsed time, lap ring and its memory.
// Depends on swlr_pkg.
module swlr_exec #(
	parameter int LAP_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [swlr_pkg::STEP_W-1:0]    tick_step,
	input  logic                           q_vld,
	input  swlr_pkg::op_t                  q_op,
	output logic                           pop,
	output logic                           vld_s1,
	output swlr_pkg::exec_res_t            res_s1,
	output logic [swlr_pkg::TIME_W-1:0]    lap_time_s1
);
	import swlr_pkg::*;

	localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
	localparam int CW = $clog2(LAP_DEPTH + 1);
	localparam int SW = (CW + 1 > 7) ? CW + 1 : 7;

	logic [TIME_W-1:0]   mem [LAP_DEPTH];

	run_st_t             st_q, st_n;
	logic [TIME_W-1:0]   elapsed_q, el_n;
	logic [AW-1:0]       head_q, head_n;
	logic [CW-1:0]       count_q, count_n;
	logic [LAPNUM_W-1:0] num_q, num_n;

	logic                go;
	logic                lap_wr;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic [TIME_W:0]     tsum;
	logic [SW-1:0]       wr_sum, wr_wrap;
	logic [SW-1:0]       rd_sum, rd_wrap;
	logic                lap_hit;
	exec_res_t           res;

	assign go  = adv && q_vld;
	assign pop = adv;

	always_comb begin
		st_n    = st_q;
		el_n    = elapsed_q;
		head_n  = head_q;
		count_n = count_q;
		num_n   = num_q;
		lap_wr  = 1'b0;

		tsum    = {1'b0, elapsed_q} + (TIME_W + 1)'(tick_step);
		wr_sum  = SW'(head_q) + SW'(count_q);
		wr_wrap = (wr_sum >= SW'(LAP_DEPTH)) ? wr_sum - SW'(LAP_DEPTH) : wr_sum;
		wr_addr = AW'(wr_wrap);

		if (q_op.tick) begin
			if (st_q == ST_RUN)
				el_n = (tsum > (TIME_W + 1)'(TIME_MAX)) ? TIME_MAX : tsum[TIME_W-1:0];
		end else if (q_op.left) begin
			if (st_q == ST_RUN) begin
				lap_wr = 1'b1;
				if (count_q == CW'(LAP_DEPTH)) begin
					// ring full: overwrite the oldest lap
					wr_addr = head_q;
					head_n  = (head_q == AW'(LAP_DEPTH - 1)) ? '0 : head_q + AW'(1);
				end else begin
					count_n = count_q + CW'(1);
				end
				num_n = num_q + LAPNUM_W'(1);
			end else begin
				el_n    = '0;
				head_n  = '0;
				count_n = '0;
				num_n   = LAPNUM_W'(1);
				if (st_q == ST_PAUSE)
					st_n = ST_IDLE;
			end
		end else if (q_op.right) begin
			st_n = (st_q == ST_RUN) ? ST_PAUSE : ST_RUN;
		end

		// newest lap sits at head + count - 1; only meaningful when lap_hit
		rd_sum  = SW'(head_q) + SW'(count_q) - SW'(1) - SW'(q_op.lap_index);
		rd_wrap = (rd_sum >= SW'(LAP_DEPTH)) ? rd_sum - SW'(LAP_DEPTH) : rd_sum;
		rd_addr = AW'(rd_wrap);
		lap_hit = q_op.rd && (SW'(q_op.lap_index) < SW'(count_q));

		res.info.run_state = run_code(st_n);
		res.info.laps_held = HELD_W'(count_n);
		res.info.lap_valid = lap_hit;
		if (q_op.rd)
			res.info.lap_number = lap_hit ?
				num_n - LAPNUM_W'(1) - LAPNUM_W'(q_op.lap_index) : '0;
		else
			res.info.lap_number = (count_n != '0) ? num_n - LAPNUM_W'(1) : '0;
		res.lap_sel = lap_hit;
		res.elapsed = el_n;
	end

	always_ff @(posedge clk) begin
		if (go && lap_wr)
			mem[wr_addr] <= elapsed_q;
		if (adv) begin
			lap_time_s1 <= mem[rd_addr];
			res_s1      <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			elapsed_q <= '0;
			head_q    <= '0;
			count_q   <= '0;
			num_q     <= LAPNUM_W'(1);
			vld_s1    <= 1'b0;
		end else begin
			if (adv)
				vld_s1 <= q_vld;
			if (go) begin
				st_q      <= st_n;
				elapsed_q <= el_n;
				head_q    <= head_n;
				count_q   <= count_n;
				num_q     <= num_n;
			end
		end
	end

endmodule

// File: design/swlr_fmt.sv
// Back end, formatting pipeline: picks the reported time, splits it into
// MM:SS:CC digits by reciprocal multiplies, and holds the output register.
// Depends on swlr_pkg.
module swlr_fmt (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic                              adv,
	input  logic                              vld_s1,
	input  swlr_pkg::exec_res_t               res_s1,
	input  logic [swlr_pkg::TIME_W-1:0]       lap_time_s1,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        run_state,
	output logic [swlr_pkg::TIME_W-1:0]       time_ms,
	output logic [3:0]                        min_tens,
	output logic [3:0]                        min_ones,
	output logic [2:0]                        sec_tens,
	output logic [3:0]                        sec_ones,
	output logic [3:0]                        centi_tens,
	output logic [3:0]                        centi_ones,
	output logic [swlr_pkg::HELD_W-1:0]       laps_held,
	output logic [swlr_pkg::LAPNUM_W-1:0]     lap_number,
	output logic                              lap_valid
);
	import swlr_pkg::*;

	// floor(x*R >> S) equals floor(x/d) over the ranges used here
	localparam logic [23:0] RCP_MIN = 24'd9162597;   // 1/60000, shift 39
	localparam logic [32:0] RCP_SEC = 33'd67109;     // 1/1000, shift 26
	localparam logic [31:0] RCP_CS  = 32'd52429;     // 1/10, shift 19

	logic [5:0]        vld;
	info_t             info_s2, info_s3, info_s4, info_s5, info_s6;
	logic [TIME_W-1:0] ms_s2, ms_s3, ms_s4, ms_s5, ms_s6;
	logic [6:0]        min_s3, min_s4, min_s5;
	logic [15:0]       rem_s4;
	logic [5:0]        sec_s5;
	logic [12:0]       cs_s5;
	digits_t           mdig_s6, sdig_s6;
	logic [6:0]        centi_s6;

	logic [TIME_W-1:0] src;
	logic [46:0]       p_min;
	logic [TIME_W-1:0] min_ms;
	logic [32:0]       p_sec;
	logic [31:0]       p_cs;
	digits_t           cdig;

	assign out_valid = vld[5];
	assign adv       = !vld[5] || !out_stall;

	always_comb begin
		src    = res_s1.lap_sel ? lap_time_s1 : res_s1.elapsed;
		p_min  = 47'(ms_s2) * 47'(RCP_MIN);
		min_ms = TIME_W'(min_s3) * TIME_W'(60000);
		p_sec  = 33'(rem_s4) * RCP_SEC;
		p_cs   = 32'(rem_s4) * RCP_CS;
		cdig   = split10(centi_s6);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s2 <= res_s1.info;
			ms_s2   <= (src > TIME_MAX) ? TIME_MAX : src;

			info_s3 <= info_s2;
			ms_s3   <= ms_s2;
			min_s3  <= p_min[45:39];

			info_s4 <= info_s3;
			ms_s4   <= ms_s3;
			min_s4  <= min_s3;
			rem_s4  <= 16'(ms_s3 - min_ms);

			info_s5 <= info_s4;
			ms_s5   <= ms_s4;
			min_s5  <= min_s4;
			sec_s5  <= p_sec[31:26];
			cs_s5   <= p_cs[31:19];

			info_s6  <= info_s5;
			ms_s6    <= ms_s5;
			mdig_s6  <= split10(min_s5);
			sdig_s6  <= split10({1'b0, sec_s5});
			centi_s6 <= 7'(cs_s5 - 13'(sec_s5) * 13'd100);

			run_state  <= info_s6.run_state;
			laps_held  <= info_s6.laps_held;
			lap_number <= info_s6.lap_number;
			lap_valid  <= info_s6.lap_valid;
			time_ms    <= ms_s6;
			min_tens   <= mdig_s6.tens;
			min_ones   <= mdig_s6.ones;
			sec_tens   <= sdig_s6.tens[2:0];
			sec_ones   <= sdig_s6.ones;
			centi_tens <= cdig.tens;
			centi_ones <= cdig.ones;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[4:0], vld_s1};
		end
	end

endmodule
